// File: rtl/dlapf_pkg.sv
// ----------------------------------------------------------------------------
// dlapf_pkg
// Shared types and constants for the delay-line allpass filter: register
// map, fixed register widths and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package dlapf_pkg;

  // Fixed register widths
  localparam int COEFF_W = 16;
  localparam int LEN_W   = 13;

  // APB register map (index = paddr[2])
  localparam logic REG_COEFF = 1'b0;
  localparam logic REG_DELAY = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // item taken: latch x, launch delay-line read
    logic mul_d;    // multiply g * d
    logic write_v;  // form v, write it into the delay line
    logic mul_v;    // multiply g * v
    logic load_y;   // form y, load the output register
  } dlapf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_free; // output register empty or being drained this cycle
  } dlapf_status_t;

endpackage

// File: rtl/dlapf_cfg.sv
// ----------------------------------------------------------------------------
// dlapf_cfg
// APB register block: allpass gain and delay length, with read-back.
// ----------------------------------------------------------------------------
module dlapf_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  output logic signed [dlapf_pkg::COEFF_W-1:0] coeff_o,
  output logic [dlapf_pkg::LEN_W-1:0]         delay_len_o
);
  import dlapf_pkg::*;

  logic signed [COEFF_W-1:0] coeff_q;
  logic [LEN_W-1:0]          delay_len_q;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q     <= '0;
      delay_len_q <= LEN_W'(1);
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_COEFF: coeff_q     <= pwdata[COEFF_W-1:0];
        REG_DELAY: delay_len_q <= pwdata[LEN_W-1:0];
        default:   ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (paddr[2])
      REG_COEFF: prdata = 32'(unsigned'(coeff_q));
      REG_DELAY: prdata = 32'(delay_len_q);
      default:   prdata = '0;
    endcase
  end

  assign coeff_o     = coeff_q;
  assign delay_len_o = delay_len_q;

endmodule

// File: rtl/dlapf_ctrl.sv
// ----------------------------------------------------------------------------
// dlapf_ctrl
// Sequencer for one item: read, g*d, v and write-back, g*v, y to output.
// ----------------------------------------------------------------------------
module dlapf_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  dlapf_pkg::dlapf_status_t status_i,
  output dlapf_pkg::dlapf_cmd_t    cmd_o
);
  import dlapf_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MULD = 5'b00010,
    S_WRV  = 5'b00100,
    S_MULV = 5'b01000,
    S_OUTY = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_MULD;
        end
      end
      S_MULD: begin
        cmd_o.mul_d = 1'b1;
        state_d     = S_WRV;
      end
      S_WRV: begin
        cmd_o.write_v = 1'b1;
        state_d       = S_MULV;
      end
      S_MULV: begin
        cmd_o.mul_v = 1'b1;
        state_d     = S_OUTY;
      end
      S_OUTY: begin
        // wait here while the previous result is still held
        if (status_i.out_free) begin
          cmd_o.load_y = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/dlapf_datapath.sv
// ----------------------------------------------------------------------------
// dlapf_datapath
// Delay-line memory, write pointer with fill tracking, one shared gain
// multiplier, rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module dlapf_datapath #(
  parameter int MAX_DELAY       = 4096,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COEFF_FRAC_BITS = 14
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  dlapf_pkg::dlapf_cmd_t                cmd_i,
  output dlapf_pkg::dlapf_status_t             status_o,
  input  logic signed [dlapf_pkg::COEFF_W-1:0] coeff_i,
  input  logic [dlapf_pkg::LEN_W-1:0]          delay_len_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0]       sample_out_o
);
  import dlapf_pkg::*;

  localparam int AW   = (MAX_DELAY > 1) ? $clog2(MAX_DELAY) : 1;
  localparam int PW   = SAMPLE_WIDTH + COEFF_W;
  localparam int SUMW = (PW + 1 > COEFF_FRAC_BITS + 2) ? PW + 1 : COEFF_FRAC_BITS + 2;
  localparam logic signed [SUMW-1:0] ROUND_C = SUMW'(1) << (COEFF_FRAC_BITS - 1);
  localparam logic signed [SUMW-1:0] SAT_HI  = (SUMW'(1) << (SAMPLE_WIDTH - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] SAT_LO  = -SAT_HI - SUMW'(1);

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat(input logic signed [SUMW-1:0] a);
    logic signed [SUMW-1:0] r;
    r = a;
    if (a > SAT_HI) r = SAT_HI;
    else if (a < SAT_LO) r = SAT_LO;
    return r[SAMPLE_WIDTH-1:0];
  endfunction

  // Delay-line storage
  logic [SAMPLE_WIDTH-1:0] mem [MAX_DELAY];

  logic [AW-1:0]                 wp_q;
  logic                          wrapped_q;
  logic [SAMPLE_WIDTH-1:0]       rdata_q;
  logic                          rd_ok_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q, d_q, v_q;
  logic signed [PW-1:0]          prod_q;
  logic                          out_valid_q;
  logic signed [SAMPLE_WIDTH-1:0] out_q;

  logic [31:0]                   len32, eff_len, wp32, rd32;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_ok;
  logic signed [SAMPLE_WIDTH-1:0] d_sel, mul_a, v_d, y_d;
  logic signed [SUMW-1:0]        rnd;

  // Read address: clamp length to 1..MAX_DELAY, step back around the ring
  always_comb begin
    len32 = 32'(delay_len_i);
    if (len32 == 32'd0) eff_len = 32'd1;
    else if (len32 > 32'(MAX_DELAY)) eff_len = 32'(MAX_DELAY);
    else eff_len = len32;
    wp32 = 32'(wp_q);
    if (wp32 >= eff_len) rd32 = wp32 - eff_len;
    else rd32 = wp32 + 32'(MAX_DELAY) - eff_len;
    rd_addr = rd32[AW-1:0];
    // entries below the write pointer, or all once it has wrapped, hold data
    rd_ok = wrapped_q | (rd_addr < wp_q);
  end

  // Arithmetic: round half up, then saturate
  assign d_sel = rd_ok_q ? signed'(rdata_q) : '0;
  assign mul_a = cmd_i.mul_v ? v_q : d_sel;
  assign rnd   = (SUMW'(prod_q) + ROUND_C) >>> COEFF_FRAC_BITS;
  assign v_d   = sat(SUMW'(x_q) + rnd);
  assign y_d   = sat(SUMW'(d_q) - rnd);

  // Memory port: one read at acceptance, one write when v is formed
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_v) begin
      mem[wp_q] <= v_d;
    end
    if (cmd_i.accept) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Pointer and fill tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      wrapped_q <= 1'b0;
    end else if (cmd_i.write_v) begin
      if (32'(wp_q) == 32'(MAX_DELAY - 1)) begin
        wp_q      <= '0;
        wrapped_q <= 1'b1;
      end else begin
        wp_q <= wp_q + AW'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q     <= sample_in_i;
      rd_ok_q <= rd_ok;
    end
    if (cmd_i.mul_d) begin
      d_q <= d_sel;
    end
    if (cmd_i.mul_d || cmd_i.mul_v) begin
      prod_q <= PW'(mul_a) * PW'(coeff_i);
    end
    if (cmd_i.write_v) begin
      v_q <= v_d;
    end
    if (cmd_i.load_y) begin
      out_q <= y_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_y) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.out_free = ~out_valid_q | out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign sample_out_o      = out_q;

endmodule

// File: rtl/delay_line_allpass_filter.sv
// ----------------------------------------------------------------------------
// delay_line_allpass_filter
// Schroeder allpass section on a whole-sample delay line with APB config.
// ----------------------------------------------------------------------------
// An item is accepted only while the block is idle. The delay-line read
// issues at the accepting edge; g*d, the feedback node v with its
// write-back, g*v and y then follow in that order (states S_MULD, S_WRV,
// S_MULV, S_OUTY) through one shared multiplier and the single-port delay
// memory, ending with the result in the output register. The block is
// ready again in the cycle after y is loaded and takes no new item before
// then; a result still held in the output register stalls the last step
// until it is taken. The delay line needs no clearing pass after reset:
// entries not yet written since reset read as zero through fill tracking
// of the write pointer. Configuration must be written only while the block
// is idle; the block itself does not enforce this.
module delay_line_allpass_filter #(
  parameter int MAX_DELAY       = 4096,
  parameter int SAMPLE_WIDTH    = 16,
  parameter int COEFF_FRAC_BITS = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import dlapf_pkg::*;

  logic signed [COEFF_W-1:0] coeff;
  logic [LEN_W-1:0]          delay_len;
  dlapf_cmd_t                cmd;
  dlapf_status_t             status;

  dlapf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .coeff_o     (coeff),
    .delay_len_o (delay_len)
  );

  dlapf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dlapf_datapath #(
    .MAX_DELAY       (MAX_DELAY),
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .coeff_i      (coeff),
    .delay_len_i  (delay_len),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

endmodule

// File: rtl/dlapf_checker.sv
// ----------------------------------------------------------------------------
// dlapf_checker
// Port-level checks for the allpass filter, bound to the top level.
// ----------------------------------------------------------------------------
module dlapf_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] sample_out_o,
  input logic                    pready
);

  // A held result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_out_o))
    else $error("output item dropped or changed while stalled");

  // One item at a time: busy right after an acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while previous item in flight");

  // A new result only appears at the end of an item's work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in flight");

  // Config port never stalls
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

endmodule

bind delay_line_allpass_filter dlapf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dlapf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o),
  .pready       (pready)
);
